// File: sv/lpct_pkg.sv
// ---------------------------------------------------------------------------
// lpct_pkg
// Types and codes shared by the page cache table modules.
// ---------------------------------------------------------------------------
`default_nettype none
package lpct_pkg;

   localparam logic [3:0] OP_PROBE     = 4'd0;
   localparam logic [3:0] OP_GET       = 4'd1;
   localparam logic [3:0] OP_MARK_HIT  = 4'd2;
   localparam logic [3:0] OP_INS_CLEAN = 4'd3;
   localparam logic [3:0] OP_INS_DIRTY = 4'd4;
   localparam logic [3:0] OP_UPD_DIRTY = 4'd5;
   localparam logic [3:0] OP_UPD_KEEP  = 4'd6;
   localparam logic [3:0] OP_WRITEBACK = 4'd7;
   localparam logic [3:0] OP_REMOVE    = 4'd8;
   localparam logic [3:0] OP_EVICT_LRU = 4'd9;
   localparam logic [3:0] OP_EVICT_DTY = 4'd10;

   localparam logic [2:0] RS_OK       = 3'd0;
   localparam logic [2:0] RS_MISS     = 3'd1;
   localparam logic [2:0] RS_DUP      = 3'd2;
   localparam logic [2:0] RS_FULL     = 3'd3;
   localparam logic [2:0] RS_EMPTY    = 3'd4;
   localparam logic [2:0] RS_NO_DIRTY = 3'd5;

   localparam logic [1:0] SL_CLEAN = 2'd0;
   localparam logic [1:0] SL_DIRTY = 2'd1;
   localparam logic [1:0] SL_WBACK = 2'd2;
   localparam logic [1:0] SL_NONE  = 2'd3;

   localparam logic [6:0] CAP_RESET = 7'd64;

   typedef struct packed {
      logic [3:0]  op;
      logic [7:0]  src_stream;
      logic [31:0] lpn;
      logic [31:0] content;
      logic [47:0] timestamp;
      logic [15:0] sector_bitmap;
      logic [6:0]  request_slots;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  out_src_stream;
      logic [31:0] out_lpn;
      logic [31:0] out_content;
      logic [47:0] out_timestamp;
      logic [15:0] out_sector_bitmap;
      logic [1:0]  out_slot_status;
      logic        out_ever_hit;
      logic [6:0]  occupancy;
      logic        is_full;
      logic        is_empty;
      logic        room_for_request;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic search;
      logic apply;
   } cmd_type;

   typedef struct packed {
      logic busy;
   } stat_type;

endpackage
`default_nettype wire

// File: sv/lpct_ctrl.sv
// ---------------------------------------------------------------------------
// lpct_ctrl
// Sequencer: load, search, apply, then hold the result beat until taken.
// ---------------------------------------------------------------------------
`default_nettype none
module lpct_ctrl
   import lpct_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   input  wire stat_type dp_stat,
   output cmd_type       dp_cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SEARCH = 2'd1;
   localparam logic [1:0] S_APPLY  = 2'd2;
   localparam logic [1:0] S_RESP   = 2'd3;

   logic [1:0] state_ff, state_in;

   assign req_ready     = (state_ff == S_IDLE) && !dp_stat.busy;
   assign rsp_valid     = (state_ff == S_RESP);
   assign dp_cmd.load   = req_valid && req_ready;
   assign dp_cmd.search = (state_ff == S_SEARCH);
   assign dp_cmd.apply  = (state_ff == S_APPLY);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid && req_ready) state_in = S_SEARCH;
         S_SEARCH: state_in = S_APPLY;
         S_APPLY:  state_in = S_RESP;
         S_RESP:   if (rsp_ready) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule
`default_nettype wire

// File: sv/lpct_dpath.sv
// ---------------------------------------------------------------------------
// lpct_dpath
// Entry tags, recency ranks and flags in registers; page data in a memory.
// ---------------------------------------------------------------------------
`default_nettype none
module lpct_dpath
   import lpct_pkg::*;
#(
   parameter int ENTRIES = 64
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type dp_cmd,
   output stat_type     dp_stat,
   input  wire req_type req_data,
   output rsp_type      rsp_data,
   input  wire logic    csr_we,
   input  wire logic [6:0] csr_wdata
);

   localparam int IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW  = $clog2(ENTRIES + 1);
   localparam int MW  = ((CW > 7) ? CW : 7) + 1;
   localparam int KW  = 40;
   localparam int DW  = 96;
   localparam logic [MW-1:0] ENT_M = MW'(ENTRIES);

   req_type             req_ff;
   logic [6:0]          cap_ff;
   logic [ENTRIES-1:0]  valid_ff, valid_in;
   logic [IW-1:0]       rank_ff [ENTRIES];
   logic [IW-1:0]       rank_in [ENTRIES];
   logic [1:0]          stat_ff [ENTRIES];
   logic [1:0]          stat_in [ENTRIES];
   logic [ENTRIES-1:0]  hitf_ff, hitf_in;
   logic [KW-1:0]       key_ff [ENTRIES];
   logic [CW-1:0]       count_ff, count_in;
   logic [KW+DW-1:0]    mem [ENTRIES];
   logic [KW+DW-1:0]    mem_rd_ff;

   logic                hit_ff, lru_ff, free_ff, dirty_ff;
   logic [IW-1:0]       hit_idx_ff, lru_idx_ff, free_idx_ff;
   logic                s_hit, s_lru, s_free, s_dirty;
   logic [IW-1:0]       s_hit_idx, s_lru_idx, s_free_idx;

   logic [2:0]          res_st_ff, res_st_in;
   logic                res_ret_ff, res_ret_in;
   logic                res_rkey_ff, res_rkey_in;
   logic                res_rdat_ff, res_rdat_in;
   logic [1:0]          res_slot_ff, res_slot_in;
   logic                res_hit_ff, res_hit_in;
   logic [6:0]          res_occ_ff;
   logic                res_full_ff, res_empty_ff, res_room_ff;
   logic                res_full_in, res_empty_in, res_room_in;

   logic [IW-1:0]       t;
   logic                mem_we;
   logic [MW-1:0]       eff;

   assign dp_stat.busy = 1'b0;
   assign eff = (MW'(cap_ff) > ENT_M) ? ENT_M : MW'(cap_ff);

   always_comb begin
      s_hit = 1'b0; s_lru = 1'b0; s_free = 1'b0; s_dirty = 1'b0;
      s_hit_idx = '0; s_lru_idx = '0; s_free_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && key_ff[i] == {req_ff.src_stream, req_ff.lpn}) begin
            s_hit = 1'b1; s_hit_idx = IW'(i);
         end
         if (valid_ff[i] && count_ff != '0 && CW'(rank_ff[i]) == count_ff - CW'(1)) begin
            s_lru = 1'b1; s_lru_idx = IW'(i);
         end
         if (!valid_ff[i]) begin
            s_free = 1'b1; s_free_idx = IW'(i);
         end
         if (valid_ff[i] && stat_ff[i] == SL_DIRTY) s_dirty = 1'b1;
      end
   end

   always_comb begin
      logic          touch, drop, ins, wr, set_hit;
      logic          sel_ok;
      logic [1:0]    new_stat;
      logic [IW-1:0] r;
      logic [1:0]    t_stat;
      logic          t_hit;
      logic [MW-1:0] occ;
      touch = 1'b0; drop = 1'b0; ins = 1'b0; wr = 1'b0; set_hit = 1'b0;
      sel_ok = 1'b0; new_stat = SL_CLEAN; t = hit_idx_ff;
      res_st_in = RS_OK; res_ret_in = 1'b0; res_rkey_in = 1'b0; res_rdat_in = 1'b0;
      res_slot_in = SL_NONE; res_hit_in = 1'b0;
      unique case (req_ff.op)
         OP_PROBE, OP_GET, OP_MARK_HIT, OP_UPD_DIRTY, OP_UPD_KEEP,
         OP_WRITEBACK, OP_REMOVE: begin
            if (!hit_ff) res_st_in = RS_MISS;
            else begin
               sel_ok = 1'b1; res_rkey_in = 1'b1;
               touch = (req_ff.op == OP_GET) || (req_ff.op == OP_MARK_HIT)
                  || (req_ff.op == OP_UPD_DIRTY) || (req_ff.op == OP_UPD_KEEP);
               set_hit = (req_ff.op == OP_MARK_HIT) || (req_ff.op == OP_UPD_DIRTY)
                  || (req_ff.op == OP_UPD_KEEP);
               wr = (req_ff.op == OP_UPD_DIRTY) || (req_ff.op == OP_UPD_KEEP);
               drop = (req_ff.op == OP_REMOVE);
            end
         end
         OP_INS_CLEAN, OP_INS_DIRTY: begin
            if (hit_ff) res_st_in = RS_DUP;
            else if (MW'(count_ff) >= eff || !free_ff) res_st_in = RS_FULL;
            else begin
               t = free_idx_ff; ins = 1'b1; wr = 1'b1; sel_ok = 1'b1;
               res_rkey_in = 1'b1;
            end
         end
         OP_EVICT_LRU, OP_EVICT_DTY: begin
            t = lru_idx_ff;
            if (count_ff == '0 || !lru_ff) res_st_in = RS_EMPTY;
            else begin
               sel_ok = 1'b1;
               if (req_ff.op == OP_EVICT_DTY && !dirty_ff) res_st_in = RS_NO_DIRTY;
               else drop = 1'b1;
            end
         end
         default: ;
      endcase

      r = '0; t_stat = SL_CLEAN; t_hit = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (IW'(i) == t) begin
            r = rank_ff[i]; t_stat = stat_ff[i]; t_hit = hitf_ff[i];
         end
      end

      new_stat = t_stat;
      if (req_ff.op == OP_UPD_DIRTY) new_stat = SL_DIRTY;
      if (req_ff.op == OP_WRITEBACK) new_stat = SL_WBACK;
      if (ins) new_stat = (req_ff.op == OP_INS_DIRTY) ? SL_DIRTY : SL_CLEAN;

      valid_in = valid_ff; hitf_in = hitf_ff; count_in = count_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
         stat_in[i] = stat_ff[i];
         if (touch && valid_ff[i] && rank_ff[i] < r) rank_in[i] = rank_ff[i] + IW'(1);
         if (drop && valid_ff[i] && rank_ff[i] > r) rank_in[i] = rank_ff[i] - IW'(1);
         if (ins && valid_ff[i]) rank_in[i] = rank_ff[i] + IW'(1);
      end
      if (sel_ok) begin
         stat_in[t] = new_stat;
         if (set_hit) hitf_in[t] = 1'b1;
         if (touch) rank_in[t] = '0;
         if (ins) begin
            valid_in[t] = 1'b1; hitf_in[t] = 1'b0; rank_in[t] = '0;
            count_in = count_ff + CW'(1);
         end
         if (drop) begin
            valid_in[t] = 1'b0;
            count_in = count_ff - CW'(1);
         end
      end
      mem_we = wr;

      if (sel_ok) begin
         res_ret_in  = 1'b1;
         res_rdat_in = wr;
         res_slot_in = (res_st_in == RS_NO_DIRTY) ? SL_NONE : new_stat;
         res_hit_in  = ins ? 1'b0 : (t_hit || set_hit);
      end
      occ = MW'(count_in);
      res_full_in  = occ >= eff;
      res_empty_in = (count_in == '0);
      res_room_in  = (occ + MW'(req_ff.request_slots)) <= eff;
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) req_ff <= req_data;
      if (dp_cmd.search) begin
         hit_ff <= s_hit; hit_idx_ff <= s_hit_idx;
         lru_ff <= s_lru; lru_idx_ff <= s_lru_idx;
         free_ff <= s_free; free_idx_ff <= s_free_idx;
         dirty_ff <= s_dirty;
      end
      if (dp_cmd.apply) begin
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
            stat_ff[i] <= stat_in[i];
         end
         hitf_ff <= hitf_in;
         if (mem_we) begin
            key_ff[t] <= {req_ff.src_stream, req_ff.lpn};
            mem[t] <= {req_ff.src_stream, req_ff.lpn, req_ff.content,
                       req_ff.timestamp, req_ff.sector_bitmap};
         end
         mem_rd_ff <= mem[t];
         res_st_ff <= res_st_in; res_ret_ff <= res_ret_in;
         res_rkey_ff <= res_rkey_in; res_rdat_ff <= res_rdat_in;
         res_slot_ff <= res_slot_in; res_hit_ff <= res_hit_in;
         res_occ_ff <= 7'(count_in);
         res_full_ff <= res_full_in; res_empty_ff <= res_empty_in;
         res_room_ff <= res_room_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         cap_ff   <= CAP_RESET;
      end else begin
         if (dp_cmd.apply) begin
            valid_ff <= valid_in;
            count_ff <= count_in;
         end
         if (csr_we) cap_ff <= csr_wdata;
      end
   end

   always_comb begin
      rsp_data = '0;
      rsp_data.status = res_st_ff;
      rsp_data.out_slot_status = res_slot_ff;
      if (res_ret_ff) begin
         {rsp_data.out_src_stream, rsp_data.out_lpn} = res_rkey_ff
            ? {req_ff.src_stream, req_ff.lpn} : mem_rd_ff[KW+DW-1:DW];
         {rsp_data.out_content, rsp_data.out_timestamp, rsp_data.out_sector_bitmap} =
            res_rdat_ff ? {req_ff.content, req_ff.timestamp, req_ff.sector_bitmap}
                        : mem_rd_ff[DW-1:0];
         rsp_data.out_ever_hit = res_hit_ff;
      end
      rsp_data.occupancy = res_occ_ff;
      rsp_data.is_full = res_full_ff;
      rsp_data.is_empty = res_empty_ff;
      rsp_data.room_for_request = res_room_ff;
   end

endmodule
`default_nettype wire

// File: sv/lru_page_cache_table_top.sv
// ---------------------------------------------------------------------------
// lru_page_cache_table_top
// Fully associative page cache with least-recently-used order.
// ---------------------------------------------------------------------------
// One request beat (req_) carries one operation; it answers with exactly one
// response beat (rsp_). Configuration: csr_we writes the capacity register.
// After the request accept come the tag search, then the rank/flag update
// with data memory access; rsp_valid rises once the update is registered.
// One operation is in flight at a time; with rsp_ready held high a new
// request is taken only after the accept, search, update and response
// steps over the tag registers. A stalled response holds rsp_valid and
// rsp_data until taken; no request is accepted meanwhile. Reset empties the
// table and sets capacity to 64; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none
module lru_page_cache_table_top
   import lpct_pkg::*;
#(
   parameter int ENTRIES = 64
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output rsp_type         rsp_data,
   input  wire logic       csr_we,
   input  wire logic [6:0] csr_wdata
);

   cmd_type  dp_cmd;
   stat_type dp_stat;

   lpct_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .dp_stat, .dp_cmd
   );

   lpct_dpath #(.ENTRIES(ENTRIES)) u_dpath (
      .clock, .reset, .dp_cmd, .dp_stat, .req_data, .rsp_data, .csr_we, .csr_wdata
   );

endmodule
`default_nettype wire

// File: sv/lpct_checker.sv
// ---------------------------------------------------------------------------
// lpct_checker
// Port-level checks on the page cache table, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
module lpct_checker
   import lpct_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat dropped or changed under stall");

   a_one_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid)
      else $error("request taken while response pending");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.is_empty == (rsp_data.occupancy == 7'd0))
      else $error("empty flag disagrees with occupancy");

   a_miss_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == RS_MISS || rsp_data.status == RS_DUP)
      |-> rsp_data.out_slot_status == SL_NONE && rsp_data.out_lpn == 32'd0)
      else $error("entry returned on miss or duplicate");

endmodule

bind lru_page_cache_table_top lpct_checker u_lpct_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_data
);
`default_nettype wire

// File: tb/sv/lru_page_cache_table_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// lru_page_cache_table_checker
// Watches the request and response channels of the page cache table, keeps a
// behavioral copy of the table with its recency order, and compares each
// response beat field by field with the oldest predicted response.
// ---------------------------------------------------------------------------
`default_nettype none
module lru_page_cache_table_checker
   import lpct_pkg::*;
#(
   parameter int ENTRIES = 64
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire req_type    req_data,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire rsp_type    rsp_data,
   input  wire logic       csr_we,
   input  wire logic [6:0] csr_wdata,
   output int              fail_count,
   output int              pending_count
);

   typedef struct {
      bit          valid;
      logic [7:0]  stream;
      logic [31:0] page;
      logic [31:0] content;
      logic [47:0] stamp;
      logic [15:0] sectors;
      logic [1:0]  slot;
      logic        hit;
      int          rank;
   } line_type;

   line_type   lines [ENTRIES];
   int         line_count;
   logic [6:0] capacity;
   rsp_type    expected_rsps [$];

   function automatic int eff_capacity();
      return (capacity < ENTRIES) ? int'(capacity) : ENTRIES;
   endfunction

   function automatic int lookup(logic [7:0] sid, logic [31:0] page);
      for (int i = 0; i < ENTRIES; i++)
         if (lines[i].valid && lines[i].stream == sid && lines[i].page == page) return i;
      return -1;
   endfunction

   function automatic void promote(int e);
      int r;
      r = lines[e].rank;
      for (int i = 0; i < ENTRIES; i++)
         if (lines[i].valid && lines[i].rank < r) lines[i].rank++;
      lines[e].rank = 0;
   endfunction

   function automatic void unlink(int e);
      int r;
      r = lines[e].rank;
      lines[e].valid = 0;
      for (int i = 0; i < ENTRIES; i++)
         if (lines[i].valid && lines[i].rank > r) lines[i].rank--;
      if (line_count > 0) line_count--;
   endfunction

   function automatic void fill_entry(ref rsp_type r, input int e);
      r.out_src_stream    = lines[e].stream;
      r.out_lpn           = lines[e].page;
      r.out_content       = lines[e].content;
      r.out_timestamp     = lines[e].stamp;
      r.out_sector_bitmap = lines[e].sectors;
      r.out_slot_status   = lines[e].slot;
      r.out_ever_hit      = lines[e].hit;
   endfunction

   function automatic rsp_type apply_op(req_type q);
      rsp_type r;
      int      e;
      int      cap;
      bit      any_dirty;
      r = '0;
      r.out_slot_status = SL_NONE;
      r.status = RS_OK;
      case (q.op)
         OP_PROBE, OP_GET, OP_MARK_HIT, OP_UPD_DIRTY, OP_UPD_KEEP, OP_WRITEBACK,
         OP_REMOVE: begin
            e = lookup(q.src_stream, q.lpn);
            if (e < 0) begin
               r.status = RS_MISS;
            end else begin
               if (q.op == OP_GET) promote(e);
               if (q.op == OP_MARK_HIT) begin
                  lines[e].hit = 1;
                  promote(e);
               end
               if (q.op == OP_UPD_DIRTY || q.op == OP_UPD_KEEP) begin
                  lines[e].content = q.content;
                  lines[e].stamp   = q.timestamp;
                  lines[e].sectors = q.sector_bitmap;
                  lines[e].hit     = 1;
                  if (q.op == OP_UPD_DIRTY) lines[e].slot = SL_DIRTY;
                  promote(e);
               end
               if (q.op == OP_WRITEBACK) lines[e].slot = SL_WBACK;
               fill_entry(r, e);
               if (q.op == OP_REMOVE) unlink(e);
            end
         end
         OP_INS_CLEAN, OP_INS_DIRTY: begin
            e = -1;
            if (lookup(q.src_stream, q.lpn) >= 0) begin
               r.status = RS_DUP;
            end else if (line_count >= eff_capacity()) begin
               r.status = RS_FULL;
            end else begin
               for (int i = 0; i < ENTRIES; i++)
                  if (!lines[i].valid && e < 0) e = i;
               if (e < 0) begin
                  r.status = RS_FULL;
               end else begin
                  for (int i = 0; i < ENTRIES; i++)
                     if (lines[i].valid) lines[i].rank++;
                  lines[e].valid   = 1;
                  lines[e].stream  = q.src_stream;
                  lines[e].page    = q.lpn;
                  lines[e].content = q.content;
                  lines[e].stamp   = q.timestamp;
                  lines[e].sectors = q.sector_bitmap;
                  lines[e].slot    = (q.op == OP_INS_DIRTY) ? SL_DIRTY : SL_CLEAN;
                  lines[e].hit     = 0;
                  lines[e].rank    = 0;
                  line_count++;
                  fill_entry(r, e);
               end
            end
         end
         OP_EVICT_LRU, OP_EVICT_DTY: begin
            e = -1;
            for (int i = 0; i < ENTRIES; i++)
               if (lines[i].valid && lines[i].rank + 1 == line_count && e < 0) e = i;
            if (line_count == 0 || e < 0) begin
               r.status = RS_EMPTY;
            end else begin
               fill_entry(r, e);
               any_dirty = 0;
               for (int i = 0; i < ENTRIES; i++)
                  if (lines[i].valid && lines[i].slot == SL_DIRTY) any_dirty = 1;
               if (q.op == OP_EVICT_DTY && !any_dirty) begin
                  r.out_slot_status = SL_NONE;
                  r.status = RS_NO_DIRTY;
               end else begin
                  unlink(e);
               end
            end
         end
         default: ;
      endcase
      cap = eff_capacity();
      r.occupancy        = line_count[6:0];
      r.is_full          = line_count >= cap;
      r.is_empty         = line_count == 0;
      r.room_for_request = line_count + int'(q.request_slots) <= cap;
      return r;
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) lines[i].valid = 0;
         line_count = 0;
         capacity = CAP_RESET;
         expected_rsps.delete();
         fail_count = 0;
      end else begin
         if (csr_we) capacity = csr_wdata;
         if (req_valid && req_ready) expected_rsps.push_back(apply_op(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report("unexpected beat", 64'(rsp_data.status), 64'd0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.status !== want.status)
                  report("status", 64'(rsp_data.status), 64'(want.status));
               if (rsp_data.out_src_stream !== want.out_src_stream)
                  report("out_src_stream", 64'(rsp_data.out_src_stream),
                         64'(want.out_src_stream));
               if (rsp_data.out_lpn !== want.out_lpn)
                  report("out_lpn", 64'(rsp_data.out_lpn), 64'(want.out_lpn));
               if (rsp_data.out_content !== want.out_content)
                  report("out_content", 64'(rsp_data.out_content), 64'(want.out_content));
               if (rsp_data.out_timestamp !== want.out_timestamp)
                  report("out_timestamp", 64'(rsp_data.out_timestamp),
                         64'(want.out_timestamp));
               if (rsp_data.out_sector_bitmap !== want.out_sector_bitmap)
                  report("out_sector_bitmap", 64'(rsp_data.out_sector_bitmap),
                         64'(want.out_sector_bitmap));
               if (rsp_data.out_slot_status !== want.out_slot_status)
                  report("out_slot_status", 64'(rsp_data.out_slot_status),
                         64'(want.out_slot_status));
               if (rsp_data.out_ever_hit !== want.out_ever_hit)
                  report("out_ever_hit", 64'(rsp_data.out_ever_hit),
                         64'(want.out_ever_hit));
               if (rsp_data.occupancy !== want.occupancy)
                  report("occupancy", 64'(rsp_data.occupancy), 64'(want.occupancy));
               if (rsp_data.is_full !== want.is_full)
                  report("is_full", 64'(rsp_data.is_full), 64'(want.is_full));
               if (rsp_data.is_empty !== want.is_empty)
                  report("is_empty", 64'(rsp_data.is_empty), 64'(want.is_empty));
               if (rsp_data.room_for_request !== want.room_for_request)
                  report("room_for_request", 64'(rsp_data.room_for_request),
                         64'(want.room_for_request));
            end
         end
      end
      pending_count = expected_rsps.size();
   end

endmodule
`default_nettype wire

// File: tb/sv/lru_page_cache_table_top_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// lru_page_cache_table_top_tb
// Drives directed and random cache operations through the page cache table
// across several capacity settings, with bursty requests and response stalls;
// the checker predicts and compares every response beat.
// ---------------------------------------------------------------------------
`default_nettype none
module lru_page_cache_table_top_tb;
   import lpct_pkg::*;

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_ready;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 0;
   rsp_type    rsp_data;
   logic       csr_we = 0;
   logic [6:0] csr_wdata = '0;
   int         fail_count;
   int         pending_count;
   int         hold_off = 0;
   logic       hold_start = 0;
   logic [7:0]  key_streams [16];
   logic [31:0] key_pages [16];

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   lru_page_cache_table_top #(.ENTRIES(64)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   lru_page_cache_table_checker #(.ENTRIES(64)) checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // receiver: own stall pattern plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_start) begin
         hold_off <= 60;
         rsp_ready <= 0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   task automatic send(req_type q);
      req_valid <= 1;
      req_data  <= q;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic pause();
      req_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   function automatic req_type make_op(logic [3:0] op, int key);
      req_type q;
      q.op            = op;
      q.src_stream    = key_streams[key];
      q.lpn           = key_pages[key];
      q.content       = $urandom;
      q.timestamp     = {16'($urandom), 32'($urandom)};
      q.sector_bitmap = 16'($urandom);
      q.request_slots = 7'($urandom_range(0, 64));
      return q;
   endfunction

   task automatic drain_and_set(logic [6:0] cap);
      req_valid <= 0;
      do @(posedge clock); while (pending_count != 0);
      repeat (8) @(posedge clock);
      csr_we    <= 1;
      csr_wdata <= cap;
      @(posedge clock);
      csr_we <= 0;
   endtask

   task automatic random_phase(int count, int keys);
      int left;
      int burst;
      req_type q;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 12);
         while (burst > 0 && left > 0) begin
            if ($urandom_range(0, 19) == 0) begin
               q = '0;
               q.op = 4'($urandom_range(11, 15));
               q.src_stream = 8'($urandom);
               q.lpn = $urandom;
               send(q);
            end else begin
               send(make_op(4'($urandom_range(OP_PROBE, OP_EVICT_DTY)),
                            int'($urandom_range(0, keys - 1))));
               left--;
            end
            burst--;
         end
         if ($urandom_range(0, 2) != 0) pause();
      end
   endtask

   initial begin
      req_type q;
      for (int i = 0; i < 16; i++) begin
         key_streams[i] = (i < 2) ? (i == 0 ? 8'h00 : 8'hFF) : 8'($urandom);
         key_pages[i]   = (i < 2) ? (i == 0 ? 32'h0 : 32'hFFFF_FFFF) : $urandom;
      end
      key_streams[2] = key_streams[3];
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty table, inserts, duplicates, every op, extremes
      send(make_op(OP_EVICT_LRU, 0));
      send(make_op(OP_EVICT_DTY, 0));
      send(make_op(OP_PROBE, 0));
      q = make_op(OP_INS_CLEAN, 0);
      q.content = '0; q.timestamp = '0; q.sector_bitmap = '0; q.request_slots = '0;
      send(q);
      q = make_op(OP_INS_CLEAN, 1);
      q.content = '1; q.timestamp = '1; q.sector_bitmap = '1; q.request_slots = 7'd64;
      send(q);
      send(make_op(OP_INS_DIRTY, 1));
      send(make_op(OP_INS_CLEAN, 2));
      send(make_op(OP_EVICT_DTY, 0));
      send(make_op(OP_INS_DIRTY, 3));
      send(make_op(OP_GET, 0));
      send(make_op(OP_MARK_HIT, 1));
      send(make_op(OP_UPD_KEEP, 2));
      send(make_op(OP_UPD_DIRTY, 0));
      send(make_op(OP_WRITEBACK, 3));
      send(make_op(OP_PROBE, 2));
      send(make_op(OP_EVICT_DTY, 0));
      send(make_op(OP_REMOVE, 1));
      send(make_op(OP_REMOVE, 1));
      send(make_op(OP_EVICT_LRU, 0));
      q = '0; q.op = 4'hF; send(q);

      drain_and_set(7'd2);
      send(make_op(OP_INS_CLEAN, 4));
      send(make_op(OP_INS_CLEAN, 5));
      send(make_op(OP_INS_CLEAN, 6));
      drain_and_set(7'd0);
      send(make_op(OP_INS_DIRTY, 7));
      random_phase(30, 8);

      // long response hold-off while requests keep coming
      drain_and_set(7'd127);
      hold_start <= 1;
      @(posedge clock);
      hold_start <= 0;
      random_phase(200, 16);
      drain_and_set(7'd64);
      for (int i = 0; i < 70; i++) begin
         q = make_op(OP_INS_CLEAN, 0);
         q.src_stream = 8'($urandom);
         q.lpn = $urandom;
         send(q);
      end
      random_phase(100, 16);
      drain_and_set(7'd5);
      random_phase(150, 8);
      drain_and_set(7'd1);
      random_phase(60, 4);
      req_valid <= 0;

      do @(posedge clock); while (pending_count != 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #2ms;
      $display("Some tests failed");
      $finish;
   end

endmodule
`default_nettype wire
